// ===== sv/pfsb_pkg.sv =====
// Shared types, constants and the pixel combine function of the sprite blitter.
`default_nettype none
package pfsb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int PAGE_ROWS         = 8;

  localparam logic REG_OFFSET_X = 1'b0;
  localparam logic REG_OFFSET_Y = 1'b1;

  localparam logic CMD_BLIT = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] OP_XOR     = 2'd0;
  localparam logic [1:0] OP_OR      = 2'd1;
  localparam logic [1:0] OP_ANDNOT  = 2'd2;
  localparam logic [1:0] OP_OR_BOTH = 2'd3;

  typedef struct packed {
    logic        skip;
    logic [10:0] col;
    logic [7:0]  page;
    logic [2:0]  shift;
  } place_t;

  function automatic logic [7:0] combine_byte(input logic [7:0] old_byte,
                                              input logic [7:0] bits,
                                              input logic [1:0] op);
    logic [7:0] res;
    case (op)
      OP_XOR:     res = old_byte ^ bits;
      OP_OR:      res = old_byte | bits;
      OP_OR_BOTH: res = old_byte | bits;
      OP_ANDNOT:  res = old_byte & ~bits;
      default:    res = old_byte ^ bits;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== sv/page_framebuffer_sprite_blit.sv =====
// Top level: sequencer around the framebuffer RAM and its read-modify-write path.
//
// Channels: in_* carries one item (blit or read) with valid/ready, out_* carries
// the framebuffer byte of a read command with valid/ready. cfg_we writes
// offset_x (index 0) or offset_y (index 1) at any time, including the clear.
// Reset clears the offsets and starts a clearing pass that writes zero to every
// framebuffer byte, one a cycle. in_ready stays low until the pass ends.
// A blit goes from acceptance to a placement state, then for each page byte it
// writes passes an address state (RAM read) and a write state on the single RAM,
// done in turn by the same unit; a page byte dropped off screen gets only the
// address state. Its byte lands in one page when the row shift is zero, else it
// straddles two. A blit clipped on its column or beyond the sprite width ends after placement.
// A read issues the RAM read at acceptance; the registered RAM data loads the
// output register in the data state once that register is free. A result waiting
// in the output register does not block acceptance; a following read holds in
// its data cycle until the receiver has taken the earlier result.
// Blits give no result.
`default_nettype none
module page_framebuffer_sprite_blit
  import pfsb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [8:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_sprite_byte,
  input  wire logic [8:0] in_pos_x,
  input  wire logic [8:0] in_pos_y,
  input  wire logic [7:0] in_sprite_width,
  input  wire logic [4:0] in_band_index,
  input  wire logic [7:0] in_column_index,
  input  wire logic [1:0] in_draw_op,
  input  wire logic       in_flip_x,
  input  wire logic [9:0] in_read_address,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_read_data
);

  localparam int PAGE_COUNT = SCREEN_HEIGHT / PAGE_ROWS;
  localparam int STORE_SIZE = SCREEN_WIDTH * PAGE_COUNT;
  localparam int AW         = $clog2(STORE_SIZE);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_ADDR,
    ST_WRITE,
    ST_RDATA
  } state_t;

  state_t        state_r;
  logic [AW-1:0] clr_cnt_r;
  logic [8:0]    offset_x_r;
  logic [8:0]    offset_y_r;
  logic [7:0]    byte_r;
  logic [8:0]    pos_x_r;
  logic [8:0]    pos_y_r;
  logic [7:0]    width_r;
  logic [4:0]    band_r;
  logic [7:0]    colidx_r;
  logic [1:0]    op_r;
  logic          flip_r;
  place_t        place_r;
  logic          part_r;
  logic [AW-1:0] addr_r;
  logic          rd_range_r;
  logic          out_valid_r;
  logic [7:0]    out_data_r;

  place_t        place;
  logic          accept;
  logic          rd_in_range;
  logic [7:0]    pg;
  logic          pg_ok;
  logic [AW-1:0] pg_addr;
  logic [15:0]   wide;
  logic [7:0]    part_bits;
  logic          more_part;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  pfsb_place #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_place (
    .pos_x        (pos_x_r),
    .pos_y        (pos_y_r),
    .offset_x     (offset_x_r),
    .offset_y     (offset_y_r),
    .sprite_width (width_r),
    .band_index   (band_r),
    .column_index (colidx_r),
    .flip_x       (flip_r),
    .place        (place)
  );

  pfsb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready      = (state_r == ST_IDLE);
  assign accept        = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign rd_in_range   = (32'(in_read_address) < 32'(STORE_SIZE));

  always_comb begin
    pg        = part_r ? place_r.page + 8'd1 : place_r.page;
    pg_ok     = !pg[7] && (32'(pg[6:0]) < 32'(PAGE_COUNT));
    pg_addr   = AW'(32'(pg[6:0]) * 32'(SCREEN_WIDTH) + 32'(place_r.col[9:0]));
    wide      = {8'd0, byte_r} << place_r.shift;
    part_bits = part_r ? wide[15:8] : wide[7:0];
    more_part = !part_r && (place_r.shift != 3'd0);

    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = combine_byte(ram_rdata, part_bits, op_r);
    ram_re    = 1'b0;
    ram_raddr = pg_addr;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = 8'd0;
      end
      ST_IDLE: begin
        ram_re    = accept && (in_cmd == CMD_READ) && rd_in_range;
        ram_raddr = AW'(in_read_address);
      end
      ST_ADDR: begin
        ram_re = pg_ok;
      end
      ST_WRITE: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      offset_x_r  <= '0;
      offset_y_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_OFFSET_X) begin
          offset_x_r <= cfg_wdata;
        end else if (cfg_index == REG_OFFSET_Y) begin
          offset_y_r <= cfg_wdata;
        end
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(STORE_SIZE - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            byte_r     <= in_sprite_byte;
            pos_x_r    <= in_pos_x;
            pos_y_r    <= in_pos_y;
            width_r    <= in_sprite_width;
            band_r     <= in_band_index;
            colidx_r   <= in_column_index;
            op_r       <= in_draw_op;
            flip_r     <= in_flip_x;
            rd_range_r <= rd_in_range;
            state_r    <= (in_cmd == CMD_READ) ? ST_RDATA : ST_CALC;
          end
        end
        ST_CALC: begin
          place_r <= place;
          part_r  <= 1'b0;
          state_r <= place.skip ? ST_IDLE : ST_ADDR;
        end
        ST_ADDR: begin
          addr_r <= pg_addr;
          if (pg_ok) begin
            state_r <= ST_WRITE;
          end else if (more_part) begin
            part_r <= 1'b1;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_WRITE: begin
          if (more_part) begin
            part_r  <= 1'b1;
            state_r <= ST_ADDR;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_RDATA: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= rd_range_r ? ram_rdata : 8'd0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/pfsb_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module pfsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/pfsb_place.sv =====
// Placement unit: destination column, page, shift and clip decision of one sprite byte.
`default_nettype none
module pfsb_place
  import pfsb_pkg::*;
#(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
  input  wire logic [8:0] pos_x,
  input  wire logic [8:0] pos_y,
  input  wire logic [8:0] offset_x,
  input  wire logic [8:0] offset_y,
  input  wire logic [7:0] sprite_width,
  input  wire logic [4:0] band_index,
  input  wire logic [7:0] column_index,
  input  wire logic       flip_x,
  output place_t          place
);

  logic [9:0]  x;
  logic [9:0]  y;
  logic [10:0] col;

  always_comb begin
    x = {pos_x[8], pos_x} + {offset_x[8], offset_x};
    y = {pos_y[8], pos_y} + {offset_y[8], offset_y};
    if (flip_x) begin
      col = {x[9], x} + {3'd0, sprite_width} - 11'd1 - {3'd0, column_index};
    end else begin
      col = {x[9], x} + {3'd0, column_index};
    end
    place.col   = col;
    place.skip  = (column_index >= sprite_width) || col[10] ||
                  (col[9:0] > 10'(SCREEN_WIDTH - 1));
    place.page  = {y[9], y[9:3]} + {3'd0, band_index};
    place.shift = y[2:0];
  end

endmodule
`default_nettype wire

// ===== sv/pfsb_checker.sv =====
// Port-level checker of the sprite blitter, bound to the top level.
`default_nettype none
module pfsb_checker
  import pfsb_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_cmd,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_read_data
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block not quiet after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted in back-to-back cycles");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_cmd == CMD_READ), 2))
    else $error("result without a read item two cycles earlier");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed");

endmodule

bind page_framebuffer_sprite_blit pfsb_checker u_pfsb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_cmd        (in_cmd),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_data (out_read_data)
);
`default_nettype wire
